[hw/rtl/kalman_angle_bias_filter_assert.svh]
// Assertion macros for the angle and bias filter.
`ifndef KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH
`define KALMAN_ANGLE_BIAS_FILTER_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define KAB_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication checked outside reset.
`define KAB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

[hw/rtl/kab_pkg.sv]
// ----------------------------------------------------------------------------
// kab_pkg
// Shared constants and helpers for the angle and bias filter.
// ----------------------------------------------------------------------------
package kab_pkg;
   localparam int CHANNELS = 2;
   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic [1:0] CSR_ANGLE_NOISE   = 2'd0;
   localparam logic [1:0] CSR_BIAS_NOISE    = 2'd1;
   localparam logic [1:0] CSR_MEASURE_NOISE = 2'd2;

   localparam logic [30:0] ANGLE_NOISE_RST   = 31'd16777;
   localparam logic [30:0] BIAS_NOISE_RST    = 31'd50332;
   localparam logic [30:0] MEASURE_NOISE_RST = 31'd503316;

   // Saturate a signed 34-bit sum to signed 32 bits.
   function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd2147483647) r = 32'sh7fffffff;
      else if (v < -34'sd2147483648) r = 32'sh80000000;
      else r = v[31:0];
      return r;
   endfunction
endpackage

[hw/rtl/kalman_angle_bias_filter.sv]
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// Two-state (angle, gyro bias) Kalman filter, one filter per channel.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample (channel, measured angle, rate, time step) per
//   transfer. rsp_* returns the filtered angle and bias of that channel.
//   csr_* writes the three noise registers (index 0..2). The user must write
//   them only while idle; the block itself does not enforce it.
// Sequencing:
//   One sample is worked by a sequencer around a single 33x32 multiplier
//   with rounding shift and a radix-2 restoring divider, 1 bit a cycle.
//   A sample in range takes two 56-bit quotients, ten multiplies and the
//   rate and inner-sum steps. A new request is taken only once the sequencer
//   is back in idle, after the result of the last one has been loaded.
// Reset:
//   All channel states clear to zero, noise registers take defaults.
// Stall:
//   The result is held in rsp_* until rsp_ready. The next sample is still
//   taken and worked; it waits in its last step until the result is gone.
//   A channel beyond CHANNELS returns zeros and leaves state unchanged.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter
   import kab_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_channel,
   input  logic signed [31:0] req_measured_angle,
   input  logic signed [31:0] req_measured_rate,
   input  logic [23:0]        req_time_step,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_channel_out,
   output logic signed [31:0] rsp_filtered_angle,
   output logic signed [31:0] rsp_rate_bias,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_data
);

   // Sequencer states
   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_RATE = 5'd1;   // rate, dp11 product
   localparam logic [4:0] S_ANG  = 5'd2;   // dt*rate
   localparam logic [4:0] S_INN  = 5'd3;   // inner sum
   localparam logic [4:0] S_P00  = 5'd4;   // dt*inner
   localparam logic [4:0] S_P11  = 5'd5;   // dt*bias_noise
   localparam logic [4:0] S_DIV0 = 5'd6;   // k0
   localparam logic [4:0] S_DIV1 = 5'd7;   // k1
   localparam logic [4:0] S_C0   = 5'd8;   // k0*innov
   localparam logic [4:0] S_C1   = 5'd9;   // k1*innov
   localparam logic [4:0] S_C2   = 5'd10;  // k0*p00
   localparam logic [4:0] S_C3   = 5'd11;  // k0*p01
   localparam logic [4:0] S_C4   = 5'd12;  // k1*p00
   localparam logic [4:0] S_C5   = 5'd13;  // k1*p01
   localparam logic [4:0] S_OUT  = 5'd14;
   localparam logic [4:0] S_MUL  = 5'd15;  // multiplier result settle
   localparam logic [4:0] S_WB   = 5'd16;  // rounded result written back

   logic [4:0] state_ff, state_in, ret_ff, ret_in;

   logic [30:0] an_ff, bn_ff, mn_ff;

   logic signed [31:0] ang_st_ff [CHANNELS];
   logic signed [31:0] bias_st_ff [CHANNELS];
   logic signed [31:0] c00_ff [CHANNELS];
   logic signed [31:0] c01_ff [CHANNELS];
   logic signed [31:0] c10_ff [CHANNELS];
   logic signed [31:0] c11_ff [CHANNELS];

   // Working registers
   logic              ch_ff;
   logic              inr_ff;
   logic signed [31:0] ma_ff, mr_ff;
   logic [23:0]       dt_ff;
   logic signed [31:0] rate_ff, ang_ff, dp11_ff, inner_ff, p00_ff, p01_ff, p10_ff,
                       p11_ff, k0_ff, k1_ff, innov_ff, bias_ff;
   logic signed [31:0] o_ang_ff, o_bias_ff;
   logic              o_ch_ff, o_vld_ff;

   logic [CH_W-1:0] ci;
   assign ci = CH_W'(ch_ff);

   // Result register loads once the previous result has left
   logic out_load;
   assign out_load = (state_ff == S_OUT) && (!o_vld_ff || rsp_ready);

   // Shared multiplier: a (33 bit signed) * b (32 bit signed), round shift
   logic signed [32:0] ma_op_ff, ma_op_in;
   logic signed [31:0] mb_op_ff, mb_op_in;
   logic              msh_ff, msh_in;      // 1: shift 24, 0: shift 16
   logic signed [64:0] prod;
   logic signed [63:0] prod_ff;
   logic              msh_q_ff;
   logic [63:0]       pmag;
   logic [63:0]       rmag;
   logic signed [33:0] mres;               // rounded, clipped to 34 bits

   assign prod = ma_op_ff * mb_op_ff;
   always_ff @(posedge clock) begin
      prod_ff  <= prod[63:0];
      msh_q_ff <= msh_ff;
   end

   always_comb begin
      pmag = prod_ff[63] ? (64'd0 - prod_ff) : prod_ff;
      if (msh_q_ff) rmag = (pmag + 64'd8388608) >> 24;
      else rmag = (pmag + 64'd32768) >> 16;
      // Clip magnitude so a 34-bit signed value still saturates correctly
      if (rmag > 64'h0000_0000_ffff_ffff) rmag = 64'h0000_0000_ffff_ffff;
      mres = prod_ff[63] ? -$signed({2'b00, rmag[31:0]}) : $signed({2'b00, rmag[31:0]});
   end

   // Restoring divider: |num| (56 bit) / |den| (33 bit), 1 bit a cycle
   logic [55:0] dq_ff;
   logic [33:0] drem_ff;
   logic [32:0] dden_ff;
   logic [5:0]  dcnt_ff;
   logic        dneg_ff;
   logic [34:0] dtry;
   assign dtry = {drem_ff, dq_ff[55]} - {2'b00, dden_ff};

   logic signed [33:0] s_val;
   assign s_val = 34'(p00_ff) + $signed({3'b000, mn_ff});

   function automatic logic [55:0] absnum(input logic signed [31:0] p);
      logic [31:0] m;
      m = p[31] ? (32'd0 - p) : p;
      return {m, 24'd0};
   endfunction

   // Quotient after the final step, saturated and signed
   function automatic logic signed [31:0] qsat_next(input logic [34:0] t,
                                                    input logic [55:0] q,
                                                    input logic neg);
      logic [55:0] qn;
      logic signed [31:0] r;
      qn = {q[54:0], ~t[34]};
      if (qn[55:31] != '0) r = neg ? 32'sh80000000 : 32'sh7fffffff;
      else r = neg ? -$signed({1'b0, qn[30:0]}) : $signed({1'b0, qn[30:0]});
      if (neg && qn == 56'h80000000) r = 32'sh80000000;
      return r;
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = o_vld_ff;
   assign rsp_channel_out = o_ch_ff;
   assign rsp_filtered_angle = o_ang_ff;
   assign rsp_rate_bias = o_bias_ff;

   // Next state and multiplier operand select
   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      ma_op_in = ma_op_ff;
      mb_op_in = mb_op_ff;
      msh_in   = msh_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) state_in = S_RATE;
         end
         S_RATE: begin
            if (!inr_ff) state_in = S_OUT;
            else begin
               ma_op_in = 33'($signed({1'b0, dt_ff}));
               mb_op_in = c11_ff[ci];
               msh_in = 1'b0;
               ret_in = S_ANG;
               state_in = S_MUL;
            end
         end
         S_ANG: begin
            ma_op_in = 33'($signed({1'b0, dt_ff}));
            mb_op_in = rate_ff;
            msh_in = 1'b0;
            ret_in = S_INN;
            state_in = S_MUL;
         end
         S_INN: state_in = S_P00;
         S_P00: begin
            ma_op_in = 33'($signed({1'b0, dt_ff}));
            mb_op_in = inner_ff;
            msh_in = 1'b0;
            ret_in = S_P11;
            state_in = S_MUL;
         end
         S_P11: begin
            ma_op_in = 33'($signed({1'b0, dt_ff}));
            mb_op_in = $signed({1'b0, bn_ff});
            msh_in = 1'b0;
            ret_in = S_DIV0;
            state_in = S_MUL;
         end
         S_DIV0: if (dcnt_ff == 6'd0) state_in = S_DIV1;
         S_DIV1: if (dcnt_ff == 6'd0) state_in = S_C0;
         S_C0: begin
            ma_op_in = 33'(k0_ff); mb_op_in = innov_ff; msh_in = 1'b1;
            ret_in = S_C1; state_in = S_MUL;
         end
         S_C1: begin
            ma_op_in = 33'(k1_ff); mb_op_in = innov_ff; msh_in = 1'b1;
            ret_in = S_C2; state_in = S_MUL;
         end
         S_C2: begin
            ma_op_in = 33'(k0_ff); mb_op_in = p00_ff; msh_in = 1'b1;
            ret_in = S_C3; state_in = S_MUL;
         end
         S_C3: begin
            ma_op_in = 33'(k0_ff); mb_op_in = p01_ff; msh_in = 1'b1;
            ret_in = S_C4; state_in = S_MUL;
         end
         S_C4: begin
            ma_op_in = 33'(k1_ff); mb_op_in = p00_ff; msh_in = 1'b1;
            ret_in = S_C5; state_in = S_MUL;
         end
         S_C5: begin
            ma_op_in = 33'(k1_ff); mb_op_in = p01_ff; msh_in = 1'b1;
            ret_in = S_OUT; state_in = S_MUL;
         end
         S_MUL: state_in = S_WB;          // product register loads
         S_WB: state_in = ret_ff;         // rounded result written back
         S_OUT: if (out_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         o_vld_ff <= 1'b0;
         an_ff <= ANGLE_NOISE_RST;
         bn_ff <= BIAS_NOISE_RST;
         mn_ff <= MEASURE_NOISE_RST;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_ANGLE_NOISE:   an_ff <= csr_data;
               CSR_BIAS_NOISE:    bn_ff <= csr_data;
               CSR_MEASURE_NOISE: mn_ff <= csr_data;
               default: ;
            endcase
         end
         if (out_load) o_vld_ff <= 1'b1;
         else if (rsp_ready) o_vld_ff <= 1'b0;
      end
   end

   // Channel state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            ang_st_ff[i] <= '0; bias_st_ff[i] <= '0;
            c00_ff[i] <= '0; c01_ff[i] <= '0; c10_ff[i] <= '0; c11_ff[i] <= '0;
         end
      end else if (state_ff == S_OUT && inr_ff) begin
         ang_st_ff[ci]  <= ang_ff;
         bias_st_ff[ci] <= bias_ff;
      end else if (state_ff == S_WB && inr_ff) begin
         unique case (ret_ff)
            S_C3:   c00_ff[ci] <= sat34(34'(p00_ff) - mres);   // after k0*p00
            S_C4:   c01_ff[ci] <= sat34(34'(p01_ff) - mres);
            S_C5:   c10_ff[ci] <= sat34(34'(p10_ff) - mres);
            S_OUT:  c11_ff[ci] <= sat34(34'(p11_ff) - mres);
            default: ;
         endcase
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      ma_op_ff <= ma_op_in;
      mb_op_ff <= mb_op_in;
      msh_ff   <= msh_in;
      if (state_ff == S_IDLE && req_valid && req_ready) begin
         ch_ff  <= req_channel;
         inr_ff <= (32'(req_channel) < 32'(CHANNELS));
         ma_ff  <= req_measured_angle;
         mr_ff  <= req_measured_rate;
         dt_ff  <= req_time_step;
      end
      unique case (state_ff)
         S_RATE: rate_ff <= sat34(34'(mr_ff) - 34'(bias_st_ff[ci]));
         S_INN: begin
            inner_ff <= sat34(34'(dp11_ff) - 34'(c01_ff[ci]) - 34'(c10_ff[ci])
                              + $signed({3'b000, an_ff}));
            p01_ff <= sat34(34'(c01_ff[ci]) - 34'(dp11_ff));
            p10_ff <= sat34(34'(c10_ff[ci]) - 34'(dp11_ff));
            innov_ff <= sat34(34'(ma_ff) - 34'(ang_ff));
         end
         S_OUT: begin
            if (out_load) begin
               o_ch_ff   <= ch_ff;
               o_ang_ff  <= inr_ff ? ang_ff : '0;
               o_bias_ff <= inr_ff ? bias_ff : '0;
            end
         end
         S_WB: begin
            unique case (ret_ff)
               S_ANG: dp11_ff <= sat34(mres);
               S_INN: ang_ff <= sat34(34'(ang_st_ff[ci]) + mres);
               S_P11: p00_ff <= sat34(34'(c00_ff[ci]) + mres);
               S_DIV0: p11_ff <= sat34(34'(c11_ff[ci]) + mres);
               S_C1: ang_ff <= sat34(34'(ang_ff) + mres);
               S_C2: bias_ff <= sat34(34'(bias_st_ff[ci]) + mres);
               default: ;
            endcase
         end
         default: ;
      endcase
   end

   // Divider sequencing: loads on entry to each divide state
   logic div_load;
   assign div_load = (state_ff == S_WB && ret_ff == S_DIV0)
                   || (state_ff == S_DIV0 && dcnt_ff == 6'd0);
   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (div_load) begin
         dcnt_ff <= 6'd56;
      end else if (dcnt_ff != 6'd0) begin
         dcnt_ff <= dcnt_ff - 6'd1;
      end
   end

   logic signed [31:0] dnum_sel;
   logic [32:0] sabs;
   assign dnum_sel = (state_ff == S_DIV0) ? p10_ff : p00_ff;
   assign sabs = s_val[33] ? 33'(-s_val) : 33'(s_val);

   always_ff @(posedge clock) begin
      if (div_load) begin
         dq_ff   <= absnum(dnum_sel);
         drem_ff <= '0;
         dden_ff <= sabs;
         dneg_ff <= dnum_sel[31] ^ s_val[33];
      end else if (dcnt_ff != 6'd0) begin
         if (!dtry[34]) begin
            drem_ff <= dtry[33:0];
            dq_ff   <= {dq_ff[54:0], 1'b1};
         end else begin
            drem_ff <= {drem_ff[32:0], dq_ff[55]};
            dq_ff   <= {dq_ff[54:0], 1'b0};
         end
      end
      // Capture gains when each divide finishes
      if (state_ff == S_DIV0 && dcnt_ff == 6'd0 && !div_load) k0_ff <= '0;
      if (state_ff == S_DIV0 && dcnt_ff == 6'd1)
         k0_ff <= (s_val == '0) ? '0 : qsat_next(dtry, dq_ff, dneg_ff);
      if (state_ff == S_DIV1 && dcnt_ff == 6'd1)
         k1_ff <= (s_val == '0) ? '0 : qsat_next(dtry, dq_ff, dneg_ff);
   end

`include "kalman_angle_bias_filter_assert.svh"
   `KAB_ASSERT_IMPL(a_busy_no_req, state_ff != S_IDLE, !req_ready, "request taken while busy")
   `KAB_ASSERT_NEXT(a_out_valid, state_ff == S_OUT, rsp_valid, "result not presented")
   `KAB_ASSERT_IMPL(a_div_range, dcnt_ff != 6'd0, state_ff == S_DIV0 || state_ff == S_DIV1,
                    "divider running outside divide states")

endmodule
